// File: hw/rtl/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants of the anagram group classifier
// Transfer payloads, the status codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package agc_pkg;

   localparam int MAX_GROUPS_DEF    = 64;
   localparam int MAX_WORD_LEN_DEF  = 31;
   localparam int ALPHABET_SIZE_DEF = 26;

   localparam int LETTER_W = 5;
   localparam int GIDX_W   = 6;

   typedef enum logic [1:0] {
      ST_JOINED   = 2'd0,
      ST_NEW      = 2'd1,
      ST_FULL     = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [GIDX_W-1:0] group_index;
      status_type        status;
   } rsp_type;

   typedef struct packed {
      logic              vld;
      logic              done;
      status_type        status;
      logic [GIDX_W-1:0] index;
   } tok_type;

endpackage

// File: hw/rtl/anagram_group_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_group_classifier_unit: sorts streamed words into anagram groups
// A word's token is registered in the accumulator, then in each group cell, then in the result register.
// Throughput: one letter per cycle; a word token visits one group cell per cycle
// while the result register is not stalled. The whole chain holds while it is.
// Reset empties every group cell at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module anagram_group_classifier_unit
   import agc_pkg::*;
#(
   parameter int MAX_GROUPS    = MAX_GROUPS_DEF,
   parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int BIN_W = $clog2(MAX_WORD_LEN + 1);

   tok_type                             tok  [MAX_GROUPS+1];
   logic [ALPHABET_SIZE-1:0][BIN_W-1:0] hist [MAX_GROUPS+1];
   logic [MAX_GROUPS-1:0]               open_vec;
   logic                                advance;
   logic                                rsp_valid_ff;
   rsp_type                             rsp_data_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;

   agc_word_accum #(
      .MAX_WORD_LEN  (MAX_WORD_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .tok       (tok[0]),
      .tok_hist  (hist[0])
   );

   for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
      agc_group_cell #(
         .MAX_WORD_LEN  (MAX_WORD_LEN),
         .ALPHABET_SIZE (ALPHABET_SIZE),
         .CELL_INDEX    (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_tok   (tok[i]),
         .in_hist  (hist[i]),
         .out_tok  (tok[i+1]),
         .out_hist (hist[i+1]),
         .open     (open_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff            <= tok[MAX_GROUPS].vld;
         rsp_data_ff.status      <= tok[MAX_GROUPS].done ? tok[MAX_GROUPS].status : ST_FULL;
         rsp_data_ff.group_index <= tok[MAX_GROUPS].done ? tok[MAX_GROUPS].index : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_open_fill: assert property (@(posedge clock) disable iff (reset)
      (open_vec & (open_vec + MAX_GROUPS'(1))) == '0)
      else $error("group cells opened out of order");

   a_full_all_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> &open_vec)
      else $error("table full reported with a free group cell");

   a_error_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_TOO_LONG)
      |-> rsp_data.group_index == '0)
      else $error("error result carries a group index");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tok[MAX_GROUPS]))
      else $error("chain tail moved while held");

endmodule

// File: hw/rtl/agc_word_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_word_accum: letter histogram of the current word
// Counts letters per transfer and launches a word token into the cell chain.
// ----------------------------------------------------------------------------
module agc_word_accum
   import agc_pkg::*;
#(
   parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   req_valid,
   output logic                                                   req_stall,
   input  req_type                                                req_data,
   input  logic                                                   advance,
   output tok_type                                                tok,
   output logic [ALPHABET_SIZE-1:0][$clog2(MAX_WORD_LEN+1)-1:0]   tok_hist
);

   localparam int BIN_W = $clog2(MAX_WORD_LEN + 1);
   localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);

   logic [ALPHABET_SIZE-1:0][BIN_W-1:0] hist_ff, hist_in;
   logic [LEN_W-1:0]                    len_ff, len_in;
   tok_type                             tok_ff;
   logic [ALPHABET_SIZE-1:0][BIN_W-1:0] tok_hist_ff;
   logic                                accept;
   logic                                counted;
   logic                                too_long;

   assign req_stall = tok_ff.vld && !advance;
   assign accept    = req_valid && !req_stall;
   assign counted   = int'(req_data.letter) < ALPHABET_SIZE;
   assign too_long  = len_in > LEN_W'(MAX_WORD_LEN);

   always_comb begin
      hist_in = hist_ff;
      len_in  = len_ff;
      if (counted) begin
         if (len_ff < LEN_W'(MAX_WORD_LEN)) begin
            len_in = len_ff + LEN_W'(1);
            for (int b = 0; b < ALPHABET_SIZE; b++) begin
               if (int'(req_data.letter) == b) begin
                  hist_in[b] = hist_ff[b] + BIN_W'(1);
               end
            end
         end else begin
            len_in = LEN_W'(MAX_WORD_LEN + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         len_ff     <= '0;
         tok_ff     <= '0;
      end else begin
         if (accept && req_data.last) begin
            tok_ff.vld <= 1'b1;
         end else if (advance) begin
            tok_ff.vld <= 1'b0;
         end
         if (accept) begin
            if (req_data.last) begin
               hist_ff       <= '0;
               len_ff        <= '0;
               tok_ff.done   <= too_long;
               tok_ff.status <= too_long ? ST_TOO_LONG : ST_JOINED;
               tok_ff.index  <= '0;
               tok_hist_ff   <= hist_in;
            end else begin
               hist_ff <= hist_in;
               len_ff  <= len_in;
            end
         end
      end
   end

   assign tok      = tok_ff;
   assign tok_hist = tok_hist_ff;

endmodule

// File: hw/rtl/agc_group_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_group_cell: one group slot of the classifier chain
// Holds a group signature, matches or claims the passing word token.
// ----------------------------------------------------------------------------
module agc_group_cell
   import agc_pkg::*;
#(
   parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
   parameter int CELL_INDEX    = 0
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   advance,
   input  tok_type                                                in_tok,
   input  logic [ALPHABET_SIZE-1:0][$clog2(MAX_WORD_LEN+1)-1:0]   in_hist,
   output tok_type                                                out_tok,
   output logic [ALPHABET_SIZE-1:0][$clog2(MAX_WORD_LEN+1)-1:0]   out_hist,
   output logic                                                   open
);

   localparam int BIN_W = $clog2(MAX_WORD_LEN + 1);

   logic                                open_ff;
   logic [ALPHABET_SIZE-1:0][BIN_W-1:0] sig_ff;
   tok_type                             out_tok_ff, out_tok_in;
   logic [ALPHABET_SIZE-1:0][BIN_W-1:0] out_hist_ff;
   logic                                claim;

   assign claim = in_tok.vld && !in_tok.done && !open_ff;

   always_comb begin
      out_tok_in = in_tok;
      if (in_tok.vld && !in_tok.done) begin
         if (!open_ff) begin
            out_tok_in.done   = 1'b1;
            out_tok_in.status = ST_NEW;
            out_tok_in.index  = GIDX_W'(CELL_INDEX);
         end else if (sig_ff == in_hist) begin
            out_tok_in.done   = 1'b1;
            out_tok_in.status = ST_JOINED;
            out_tok_in.index  = GIDX_W'(CELL_INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         out_tok_ff <= '0;
      end else if (advance) begin
         out_tok_ff  <= out_tok_in;
         out_hist_ff <= in_hist;
         if (claim) begin
            open_ff <= 1'b1;
            sig_ff  <= in_hist;
         end
      end
   end

   assign out_tok  = out_tok_ff;
   assign out_hist = out_hist_ff;
   assign open     = open_ff;

endmodule
